// ===== src/sqpq_pkg.sv =====
// Shared types, codes and compare helper for the sorted two-key priority queue.
package sqpq_pkg;

    localparam int KEY_W  = 32;
    localparam int TAG_W  = 32;
    localparam int CNT_W  = 5;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [2:0] FUNC_INSERT  = 3'd0;
    localparam logic [2:0] FUNC_PEEK    = 3'd1;
    localparam logic [2:0] FUNC_ADVANCE = 3'd2;
    localparam logic [2:0] FUNC_REMOVE  = 3'd3;
    localparam logic [2:0] FUNC_REWIND  = 3'd4;
    localparam logic [2:0] FUNC_STATUS  = 3'd5;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_DUP      = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NO_ENTRY = 2'd3;

    localparam logic [1:0] DIR_ANY  = 2'd0;
    localparam logic [1:0] DIR_ASC  = 2'd1;
    localparam logic [1:0] DIR_DESC = 2'd2;

    localparam logic [1:0] REG_PDIR      = 2'd0;
    localparam logic [1:0] REG_SDIR      = 2'd1;
    localparam logic [1:0] REG_SEC_EN    = 2'd2;
    localparam logic [1:0] REG_ALLOW_DUP = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic signed [KEY_W-1:0] primary;
        logic signed [KEY_W-1:0] secondary;
        logic [TAG_W-1:0]        tag;
    } t_entry;

    typedef struct packed {
        logic [1:0] pdir;
        logic [1:0] sdir;
        logic       sec_en;
        logic       allow_dup;
    } t_cfg;

    typedef struct packed {
        t_entry new_entry;
        t_cfg   cfg;
        logic   cmp_en;
        logic   ins_commit;
        logic   rem_commit;
    } t_cell_ctl;

    typedef struct packed {
        logic found;
        logic before_cur;
    } t_chain;

    typedef struct packed {
        logic [2:0]              func;
        t_entry                  entry;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic             entry_valid;
        t_entry           entry;
        logic             queue_empty;
        logic [CNT_W-1:0] entry_count;
    } t_rsp;

    function automatic logic favours(input logic [1:0] dir,
                                     input logic signed [KEY_W-1:0] a,
                                     input logic signed [KEY_W-1:0] b);
        logic res;
        case (dir)
            DIR_ANY:  res = 1'b1;
            DIR_DESC: res = a > b;
            default:  res = a < b;
        endcase
        return res;
    endfunction

endpackage

// ===== src/sqpq_if.sv =====
// Request and response channel interfaces of the sorted two-key priority queue.
interface sqpq_req_if;
    logic                    valid;
    logic                    ready;
    logic [2:0]              func;
    logic signed [31:0]      new_primary_key;
    logic signed [31:0]      new_secondary_key;
    logic [31:0]             new_tag;

    modport source (output valid, func, new_primary_key, new_secondary_key, new_tag,
                    input ready);
    modport sink (input valid, func, new_primary_key, new_secondary_key, new_tag,
                  output ready);
endinterface

interface sqpq_rsp_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic                    entry_valid;
    logic signed [31:0]      entry_primary_key;
    logic signed [31:0]      entry_secondary_key;
    logic [31:0]             entry_tag;
    logic                    queue_empty;
    logic [4:0]              entry_count;

    modport source (output valid, status, entry_valid, entry_primary_key,
                    entry_secondary_key, entry_tag, queue_empty, entry_count,
                    input ready);
    modport sink (input valid, status, entry_valid, entry_primary_key,
                  entry_secondary_key, entry_tag, queue_empty, entry_count,
                  output ready);
endinterface

// ===== src/sqpq_cfg.sv =====
// APB-style configuration register bank of the priority queue.
module sqpq_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sqpq_pkg::ADDR_W-1:0] paddr,
    input  logic [sqpq_pkg::DATA_W-1:0] pwdata,
    output logic [sqpq_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output sqpq_pkg::t_cfg              o_cfg
);

    sqpq_pkg::t_cfg r_cfg;
    sqpq_pkg::t_cfg n_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (paddr[3:2])
                sqpq_pkg::REG_PDIR:      n_cfg.pdir      = pwdata[1:0];
                sqpq_pkg::REG_SDIR:      n_cfg.sdir      = pwdata[1:0];
                sqpq_pkg::REG_SEC_EN:    n_cfg.sec_en    = pwdata[0];
                sqpq_pkg::REG_ALLOW_DUP: n_cfg.allow_dup = pwdata[0];
                default:                 n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pdir      <= sqpq_pkg::DIR_ASC;
            r_cfg.sdir      <= sqpq_pkg::DIR_ASC;
            r_cfg.sec_en    <= 1'b0;
            r_cfg.allow_dup <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[3:2])
            sqpq_pkg::REG_PDIR:      prdata = {30'd0, r_cfg.pdir};
            sqpq_pkg::REG_SDIR:      prdata = {30'd0, r_cfg.sdir};
            sqpq_pkg::REG_SEC_EN:    prdata = {31'd0, r_cfg.sec_en};
            sqpq_pkg::REG_ALLOW_DUP: prdata = {31'd0, r_cfg.allow_dup};
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== src/sqpq_cell.sv =====
// One storage cell of the sorted chain: compare against the broadcast key, then shift.
module sqpq_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                          i_clk,
    input  sqpq_pkg::t_cell_ctl           i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]    i_occ,
    input  logic [$clog2(DEPTH+1)-1:0]    i_cursor,
    input  sqpq_pkg::t_entry              i_left,
    input  sqpq_pkg::t_entry              i_right,
    input  sqpq_pkg::t_chain              i_chain,
    output sqpq_pkg::t_chain              o_chain,
    output logic                          o_tie_first,
    output sqpq_pkg::t_entry              o_entry,
    output sqpq_pkg::t_entry              o_sel
);

    localparam int             CW    = $clog2(DEPTH + 1);
    localparam logic [CW-1:0]  IDX_V = CW'(IDX);

    sqpq_pkg::t_entry r_entry;
    sqpq_pkg::t_entry n_entry;
    logic             r_stop;
    logic             r_tie;
    logic             w_valid;
    logic             w_stop;
    logic             w_tie;
    logic             w_first;
    logic             w_take_new;

    assign w_valid = IDX_V < i_occ;

    always_comb begin
        w_tie  = 1'b0;
        if (i_ctl.new_entry.primary != r_entry.primary) begin
            w_stop = sqpq_pkg::favours(i_ctl.cfg.pdir, i_ctl.new_entry.primary,
                                       r_entry.primary);
        end else if (!i_ctl.cfg.sec_en ||
                     i_ctl.new_entry.secondary == r_entry.secondary) begin
            w_stop = 1'b1;
            w_tie  = 1'b1;
        end else begin
            w_stop = sqpq_pkg::favours(i_ctl.cfg.sdir, i_ctl.new_entry.secondary,
                                       r_entry.secondary);
        end
    end

    assign w_first            = r_stop & ~i_chain.found;
    assign o_chain.found      = i_chain.found | r_stop;
    assign o_chain.before_cur = i_chain.before_cur | (r_stop & (IDX_V < i_cursor));
    assign o_tie_first        = w_first & r_tie;
    assign w_take_new         = w_first | ((IDX_V == i_occ) & ~i_chain.found);
    assign o_entry            = r_entry;
    assign o_sel              = (IDX_V == i_cursor) ? r_entry : '0;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_commit) begin
            if (w_take_new) begin
                n_entry = i_ctl.new_entry;
            end else if (i_chain.found) begin
                n_entry = i_left;
            end
        end else if (i_ctl.rem_commit && (IDX_V >= i_cursor)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.cmp_en) begin
            r_stop <= w_valid & w_stop;
            r_tie  <= w_tie;
        end
    end

endmodule

// ===== src/sorted_two_key_priority_queue_top.sv =====
// Top level of the sorted two-key priority queue: sequencer, cell chain and result register.
//
//  channel  | direction | handshake          | contents
//  i_req    | in        | valid/ready        | func, new keys, new tag
//  o_rsp    | out       | valid/ready        | status, entry at cursor, count
//  APB      | in/out    | psel/penable/pready| four configuration registers
//
// Each request passes through ST_CMP, where the cells compare their entries against
// the broadcast key, and then ST_UPD, where the chain shifts and the result is formed;
// a new request is taken in ST_IDLE, or in ST_UPD once the output register is free.
// Reset empties the queue and rewinds the cursor at once, with no clearing pass.
// A result that is not taken holds the sequencer in ST_UPD until the output register frees.
module sorted_two_key_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sqpq_req_if.sink                    i_req,
    sqpq_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sqpq_pkg::ADDR_W-1:0] paddr,
    input  logic [sqpq_pkg::DATA_W-1:0] pwdata,
    output logic [sqpq_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int            CW    = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL  = CW'(DEPTH);

    sqpq_pkg::t_state    r_state;
    sqpq_pkg::t_state    n_state;
    sqpq_pkg::t_req      r_req;
    sqpq_pkg::t_rsp      r_out;
    sqpq_pkg::t_rsp      n_out;
    logic                r_out_valid;
    sqpq_pkg::t_entry    r_sel;
    logic [CW-1:0]       r_occ;
    logic [CW-1:0]       n_occ;
    logic [CW-1:0]       r_cursor;
    logic [CW-1:0]       n_cursor;
    logic                r_past_end;
    logic                n_past_end;

    sqpq_pkg::t_cfg      w_cfg;
    sqpq_pkg::t_cell_ctl w_ctl;
    sqpq_pkg::t_chain    w_chain [DEPTH+1];
    sqpq_pkg::t_entry    w_entry [DEPTH];
    sqpq_pkg::t_entry    w_cell_sel [DEPTH];
    sqpq_pkg::t_entry    w_sel;
    logic [DEPTH-1:0]    w_tie;
    logic                w_accept;
    logic                w_out_free;
    logic                w_upd_fire;
    logic                w_cmp_en;
    logic                w_drop;
    logic                w_full;
    logic                w_has_entry;
    logic [CW+4:0]       w_cnt_ext;

    sqpq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_out_free = ~r_out_valid | o_rsp.ready;

    always_comb begin
        case (r_state)
            sqpq_pkg::ST_IDLE: n_state = i_req.valid ? sqpq_pkg::ST_CMP : sqpq_pkg::ST_IDLE;
            sqpq_pkg::ST_CMP:  n_state = sqpq_pkg::ST_UPD;
            sqpq_pkg::ST_UPD: begin
                if (!w_out_free) begin
                    n_state = sqpq_pkg::ST_UPD;
                end else if (i_req.valid) begin
                    n_state = sqpq_pkg::ST_CMP;
                end else begin
                    n_state = sqpq_pkg::ST_IDLE;
                end
            end
            default:           n_state = sqpq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        w_cmp_en    = 1'b0;
        w_upd_fire  = 1'b0;
        case (r_state)
            sqpq_pkg::ST_IDLE: i_req.ready = 1'b1;
            sqpq_pkg::ST_CMP:  w_cmp_en    = 1'b1;
            sqpq_pkg::ST_UPD: begin
                i_req.ready = w_out_free;
                w_upd_fire  = w_out_free;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_req.valid & i_req.ready;

    assign w_ctl.new_entry  = r_req.entry;
    assign w_ctl.cfg        = w_cfg;
    assign w_ctl.cmp_en     = w_cmp_en;
    assign w_ctl.ins_commit = w_upd_fire & (r_req.func == sqpq_pkg::FUNC_INSERT) &
                              ~w_drop & ~w_full;
    assign w_ctl.rem_commit = w_upd_fire & (r_req.func == sqpq_pkg::FUNC_REMOVE) &
                              w_has_entry;

    assign w_chain[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sqpq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (r_occ),
            .i_cursor    (r_cursor),
            .i_left      ((g == 0) ? r_req.entry : w_entry[(g == 0) ? 0 : g - 1]),
            .i_right     (w_entry[(g == DEPTH - 1) ? g : g + 1]),
            .i_chain     (w_chain[g]),
            .o_chain     (w_chain[g+1]),
            .o_tie_first (w_tie[g]),
            .o_entry     (w_entry[g]),
            .o_sel       (w_cell_sel[g])
        );
    end

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_sel = w_sel | w_cell_sel[k];
        end
    end

    assign w_drop      = (|w_tie) & ~w_cfg.allow_dup;
    assign w_full      = r_occ == FULL;
    assign w_has_entry = ~r_past_end & (r_cursor < r_occ);

    always_comb begin
        n_occ             = r_occ;
        n_cursor          = r_cursor;
        n_past_end        = r_past_end;
        n_out             = '0;
        n_out.status      = sqpq_pkg::STAT_OK;
        case (r_req.func)
            sqpq_pkg::FUNC_INSERT: begin
                if (w_drop) begin
                    n_out.status = sqpq_pkg::STAT_DUP;
                end else if (w_full) begin
                    n_out.status = sqpq_pkg::STAT_FULL;
                end else begin
                    n_occ = r_occ + 1'b1;
                    if (!r_past_end && w_chain[DEPTH].before_cur) begin
                        n_cursor = r_cursor + 1'b1;
                    end
                end
            end
            sqpq_pkg::FUNC_PEEK, sqpq_pkg::FUNC_ADVANCE, sqpq_pkg::FUNC_REMOVE: begin
                if (!w_has_entry) begin
                    n_out.status = sqpq_pkg::STAT_NO_ENTRY;
                    if (r_req.func == sqpq_pkg::FUNC_ADVANCE) begin
                        n_past_end = 1'b1;
                    end
                end else begin
                    n_out.entry_valid = 1'b1;
                    n_out.entry       = r_sel;
                    if (r_req.func == sqpq_pkg::FUNC_ADVANCE) begin
                        n_cursor = r_cursor + 1'b1;
                    end else if (r_req.func == sqpq_pkg::FUNC_REMOVE) begin
                        n_occ = r_occ - 1'b1;
                    end
                end
            end
            sqpq_pkg::FUNC_REWIND: begin
                n_cursor   = '0;
                n_past_end = 1'b0;
            end
            default: begin
                n_occ = r_occ;
            end
        endcase
        w_cnt_ext         = {5'd0, n_occ};
        n_out.queue_empty = n_occ == '0;
        n_out.entry_count = w_cnt_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sqpq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_occ       <= '0;
            r_cursor    <= '0;
            r_past_end  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd_fire) begin
                r_out_valid <= 1'b1;
                r_occ       <= n_occ;
                r_cursor    <= n_cursor;
                r_past_end  <= n_past_end;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.func            <= i_req.func;
            r_req.entry.primary   <= i_req.new_primary_key;
            r_req.entry.secondary <= i_req.new_secondary_key;
            r_req.entry.tag       <= i_req.new_tag;
        end
        if (w_cmp_en) begin
            r_sel <= w_sel;
        end
        if (w_upd_fire) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid               = r_out_valid;
    assign o_rsp.status              = r_out.status;
    assign o_rsp.entry_valid         = r_out.entry_valid;
    assign o_rsp.entry_primary_key   = r_out.entry.primary;
    assign o_rsp.entry_secondary_key = r_out.entry.secondary;
    assign o_rsp.entry_tag           = r_out.entry.tag;
    assign o_rsp.queue_empty         = r_out.queue_empty;
    assign o_rsp.entry_count         = r_out.entry_count;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the sorted two-key priority queue.
`timescale 1ns / 100ps

module testbench;

    localparam int QDEPTH = 16;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 130;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;
    localparam logic [1:0] DIR_SPARE = 2'd3;
    localparam logic [31:0] KEY_MIN = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;

    typedef enum {PLACE_BEFORE, PLACE_TIE, PLACE_AFTER} t_place;

    typedef struct {
        sqpq_pkg::t_req req;
        bit             fixed;
        sqpq_pkg::t_rsp rsp;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [sqpq_pkg::ADDR_W-1:0] paddr;
    logic [sqpq_pkg::DATA_W-1:0] pwdata;
    logic [sqpq_pkg::DATA_W-1:0] prdata;
    logic pready;

    sqpq_req_if req_ch();
    sqpq_rsp_if rsp_ch();

    sorted_two_key_priority_queue_top #(.DEPTH(QDEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sqpq_pkg::t_entry slot [QDEPTH];
    int               held_count;
    int               cursor_pos;
    logic             cursor_off_end;
    sqpq_pkg::t_cfg   cfg_shadow;
    sqpq_pkg::t_rsp   pending_rsp [$];
    sqpq_pkg::t_rsp   rsp_want;
    t_plan_row        plan_q [$];
    int               mismatches = 0;
    int               burst_left = 0;
    int               stall_left = 0;
    int               stall_mode = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic new_wins(input logic [1:0] dir, input logic signed [31:0] a,
                                      input logic signed [31:0] b);
        if (dir == sqpq_pkg::DIR_ANY) begin
            return 1'b1;
        end
        if (dir == sqpq_pkg::DIR_DESC) begin
            return a > b;
        end
        return a < b;
    endfunction

    function automatic t_place place_of(input sqpq_pkg::t_entry cand,
                                        input sqpq_pkg::t_entry held);
        if (cand.primary != held.primary) begin
            return new_wins(cfg_shadow.pdir, cand.primary, held.primary) ? PLACE_BEFORE
                                                                        : PLACE_AFTER;
        end
        if (!cfg_shadow.sec_en || cand.secondary == held.secondary) begin
            return PLACE_TIE;
        end
        return new_wins(cfg_shadow.sdir, cand.secondary, held.secondary) ? PLACE_BEFORE
                                                                        : PLACE_AFTER;
    endfunction

    task automatic predict_queue_step(input sqpq_pkg::t_req r, output sqpq_pkg::t_rsp rsp);
        int     pos;
        int     i;
        t_place pl;
        logic   found;
        logic   drop;
        logic   has_entry;
        rsp = '0;
        has_entry = !cursor_off_end && (cursor_pos < held_count);
        case (r.func)
            sqpq_pkg::FUNC_INSERT: begin
                pos = held_count;
                found = 1'b0;
                drop = 1'b0;
                for (i = 0; i < held_count; i++) begin
                    if (!found) begin
                        pl = place_of(r.entry, slot[i]);
                        if (pl != PLACE_AFTER) begin
                            pos = i;
                            found = 1'b1;
                            drop = (pl == PLACE_TIE) && !cfg_shadow.allow_dup;
                        end
                    end
                end
                if (drop) begin
                    rsp.status = sqpq_pkg::STAT_DUP;
                end else if (held_count >= QDEPTH) begin
                    rsp.status = sqpq_pkg::STAT_FULL;
                end else begin
                    for (i = held_count; i > pos; i--) begin
                        slot[i] = slot[i-1];
                    end
                    slot[pos] = r.entry;
                    held_count++;
                    if (!cursor_off_end && pos < cursor_pos) begin
                        cursor_pos++;
                    end
                    rsp.status = sqpq_pkg::STAT_OK;
                end
            end
            sqpq_pkg::FUNC_PEEK, sqpq_pkg::FUNC_ADVANCE, sqpq_pkg::FUNC_REMOVE: begin
                if (!has_entry) begin
                    rsp.status = sqpq_pkg::STAT_NO_ENTRY;
                    if (r.func == sqpq_pkg::FUNC_ADVANCE) begin
                        cursor_off_end = 1'b1;
                    end
                end else begin
                    rsp.status = sqpq_pkg::STAT_OK;
                    rsp.entry_valid = 1'b1;
                    rsp.entry = slot[cursor_pos];
                    if (r.func == sqpq_pkg::FUNC_ADVANCE) begin
                        cursor_pos++;
                    end else if (r.func == sqpq_pkg::FUNC_REMOVE) begin
                        for (i = cursor_pos; i + 1 < held_count; i++) begin
                            slot[i] = slot[i+1];
                        end
                        held_count--;
                    end
                end
            end
            sqpq_pkg::FUNC_REWIND: begin
                cursor_pos = 0;
                cursor_off_end = 1'b0;
                rsp.status = sqpq_pkg::STAT_OK;
            end
            default: begin
                rsp.status = sqpq_pkg::STAT_OK;
            end
        endcase
        rsp.queue_empty = (held_count == 0);
        rsp.entry_count = sqpq_pkg::CNT_W'(held_count);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input sqpq_pkg::t_rsp want);
        if (rsp_ch.status !== want.status) begin
            report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        end
        if (rsp_ch.entry_valid !== want.entry_valid) begin
            report_mismatch("entry_valid", 32'(rsp_ch.entry_valid), 32'(want.entry_valid));
        end
        if (rsp_ch.entry_primary_key !== want.entry.primary) begin
            report_mismatch("entry_primary_key", rsp_ch.entry_primary_key, want.entry.primary);
        end
        if (rsp_ch.entry_secondary_key !== want.entry.secondary) begin
            report_mismatch("entry_secondary_key", rsp_ch.entry_secondary_key,
                            want.entry.secondary);
        end
        if (rsp_ch.entry_tag !== want.entry.tag) begin
            report_mismatch("entry_tag", rsp_ch.entry_tag, want.entry.tag);
        end
        if (rsp_ch.queue_empty !== want.queue_empty) begin
            report_mismatch("queue_empty", 32'(rsp_ch.queue_empty), 32'(want.queue_empty));
        end
        if (rsp_ch.entry_count !== want.entry_count) begin
            report_mismatch("entry_count", 32'(rsp_ch.entry_count), 32'(want.entry_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", 32'(rsp_ch.status), 32'd0);
            end else begin
                rsp_want = pending_rsp.pop_front();
                check_result(rsp_want);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= $urandom_range(0, 1);
            default: rsp_ch.ready <= ((stall_left % 7) > 2);
        endcase
    end

    function automatic logic [31:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return 32'($urandom_range(0, 7)) - 32'd4;
        end
        if (sel < 7) begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return 32'd0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic sqpq_pkg::t_req make_req(input logic [2:0] func, input logic [31:0] p,
                                                input logic [31:0] s,
                                                input logic [31:0] tag);
        sqpq_pkg::t_req r;
        r.func = func;
        r.entry.primary = p;
        r.entry.secondary = s;
        r.entry.tag = tag;
        return r;
    endfunction

    task automatic plan_fixed(input logic [2:0] func, input logic [31:0] p,
                              input logic [31:0] s, input logic [31:0] tag,
                              input logic [1:0] status, input logic ev,
                              input logic [31:0] ep, input logic [31:0] es,
                              input logic [31:0] et, input int cnt);
        t_plan_row row;
        row.req = make_req(func, p, s, tag);
        row.fixed = 1'b1;
        row.rsp.status = status;
        row.rsp.entry_valid = ev;
        row.rsp.entry.primary = ep;
        row.rsp.entry.secondary = es;
        row.rsp.entry.tag = et;
        row.rsp.queue_empty = (cnt == 0);
        row.rsp.entry_count = sqpq_pkg::CNT_W'(cnt);
        plan_q.push_back(row);
    endtask

    task automatic plan_model(input logic [2:0] func, input logic [31:0] p,
                              input logic [31:0] s, input logic [31:0] tag);
        t_plan_row row;
        row.req = make_req(func, p, s, tag);
        row.fixed = 1'b0;
        row.rsp = '0;
        plan_q.push_back(row);
    endtask

    task automatic drive_request(input sqpq_pkg::t_req r, input bit fixed,
                                 input sqpq_pkg::t_rsp fixed_rsp);
        sqpq_pkg::t_rsp pred;
        req_ch.valid <= 1'b1;
        req_ch.func <= r.func;
        req_ch.new_primary_key <= r.entry.primary;
        req_ch.new_secondary_key <= r.entry.secondary;
        req_ch.new_tag <= r.entry.tag;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        predict_queue_step(r, pred);
        pending_rsp.push_back(fixed ? fixed_rsp : pred);
        @(negedge i_clk);
    endtask

    task automatic pace_sender(input bit no_idle);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_drain();
        while (pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) begin
            @(posedge i_clk);
        end
        case (idx)
            sqpq_pkg::REG_PDIR: cfg_shadow.pdir = value[1:0];
            sqpq_pkg::REG_SDIR: cfg_shadow.sdir = value[1:0];
            sqpq_pkg::REG_SEC_EN: cfg_shadow.sec_en = value[0];
            default: cfg_shadow.allow_dup = value[0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_config(input sqpq_pkg::t_cfg c);
        write_register(sqpq_pkg::REG_PDIR, 32'(c.pdir));
        write_register(sqpq_pkg::REG_SDIR, 32'(c.sdir));
        write_register(sqpq_pkg::REG_SEC_EN, 32'(c.sec_en));
        write_register(sqpq_pkg::REG_ALLOW_DUP, 32'(c.allow_dup));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        sqpq_pkg::t_req item;
        sqpq_pkg::t_cfg phase_cfg;
        logic [2:0]     func_code;
        int             phase;
        int             n;
        int             roll;
        int             op_bias;
        int             bias_left;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.func = sqpq_pkg::FUNC_STATUS;
        req_ch.new_primary_key = '0;
        req_ch.new_secondary_key = '0;
        req_ch.new_tag = '0;
        rsp_ch.ready = 1'b0;
        held_count = 0;
        cursor_pos = 0;
        cursor_off_end = 1'b0;
        cfg_shadow.pdir = sqpq_pkg::DIR_ASC;
        cfg_shadow.sdir = sqpq_pkg::DIR_ASC;
        cfg_shadow.sec_en = 1'b0;
        cfg_shadow.allow_dup = 1'b1;
        op_bias = 0;
        bias_left = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        plan_fixed(sqpq_pkg::FUNC_STATUS, 0, 0, 0, sqpq_pkg::STAT_OK, 0, 0, 0, 0, 0);
        plan_fixed(sqpq_pkg::FUNC_PEEK, 0, 0, 0, sqpq_pkg::STAT_NO_ENTRY, 0, 0, 0, 0, 0);
        plan_fixed(sqpq_pkg::FUNC_ADVANCE, 0, 0, 0, sqpq_pkg::STAT_NO_ENTRY, 0, 0, 0, 0, 0);
        plan_fixed(sqpq_pkg::FUNC_INSERT, KEY_MAX, 0, 32'hFFFF_FFFF,
                   sqpq_pkg::STAT_OK, 0, 0, 0, 0, 1);
        plan_fixed(sqpq_pkg::FUNC_PEEK, 0, 0, 0, sqpq_pkg::STAT_NO_ENTRY, 0, 0, 0, 0, 1);
        plan_fixed(sqpq_pkg::FUNC_REWIND, 0, 0, 0, sqpq_pkg::STAT_OK, 0, 0, 0, 0, 1);
        plan_fixed(sqpq_pkg::FUNC_INSERT, KEY_MIN, KEY_MAX, 0,
                   sqpq_pkg::STAT_OK, 0, 0, 0, 0, 2);
        plan_fixed(sqpq_pkg::FUNC_PEEK, 0, 0, 0,
                   sqpq_pkg::STAT_OK, 1, KEY_MIN, KEY_MAX, 0, 2);
        plan_model(sqpq_pkg::FUNC_INSERT, 0, KEY_MIN, 32'h5A5A_5A5A);
        plan_model(sqpq_pkg::FUNC_ADVANCE, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_INSERT, 0, 32'hFFFF_FFFF, 32'h0000_0001);
        plan_model(sqpq_pkg::FUNC_PEEK, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_REMOVE, 0, 0, 0);
        plan_model(FUNC_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        plan_model(FUNC_SPARE7, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_ADVANCE, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_ADVANCE, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_ADVANCE, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_REMOVE, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_REWIND, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_REMOVE, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_REMOVE, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_REMOVE, 0, 0, 0);
        plan_model(sqpq_pkg::FUNC_STATUS, 0, 0, 0);

        foreach (plan_q[k]) begin
            pace_sender(1'b0);
            drive_request(plan_q[k].req, plan_q[k].fixed, plan_q[k].rsp);
        end
        req_ch.valid <= 1'b0;
        wait_drain();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: phase_cfg = '{pdir: sqpq_pkg::DIR_ANY, sdir: sqpq_pkg::DIR_ANY,
                                 sec_en: 1'b0, allow_dup: 1'b0};
                1: phase_cfg = '{pdir: sqpq_pkg::DIR_DESC, sdir: sqpq_pkg::DIR_DESC,
                                 sec_en: 1'b1, allow_dup: 1'b0};
                2: phase_cfg = '{pdir: DIR_SPARE, sdir: DIR_SPARE, sec_en: 1'b1,
                                 allow_dup: 1'b1};
                3: phase_cfg = '{pdir: sqpq_pkg::DIR_ASC, sdir: sqpq_pkg::DIR_DESC,
                                 sec_en: 1'b1, allow_dup: 1'b0};
                4: phase_cfg = '{pdir: sqpq_pkg::DIR_ASC, sdir: sqpq_pkg::DIR_ANY,
                                 sec_en: 1'b1, allow_dup: 1'b1};
                default: begin
                    phase_cfg.pdir = $urandom_range(0, 3);
                    phase_cfg.sdir = $urandom_range(0, 3);
                    phase_cfg.sec_en = $urandom_range(0, 1);
                    phase_cfg.allow_dup = $urandom_range(0, 1);
                end
            endcase
            write_config(phase_cfg);

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (bias_left == 0) begin
                    op_bias = $urandom_range(0, 3);
                    bias_left = $urandom_range(10, 40);
                end
                bias_left--;
                roll = $urandom_range(0, 99);
                case (op_bias)
                    0: func_code = (roll < 70) ? sqpq_pkg::FUNC_INSERT :
                                   (roll < 80) ? sqpq_pkg::FUNC_PEEK :
                                   (roll < 90) ? sqpq_pkg::FUNC_ADVANCE :
                                   (roll < 95) ? sqpq_pkg::FUNC_REWIND :
                                                 sqpq_pkg::FUNC_REMOVE;
                    1: func_code = (roll < 10) ? sqpq_pkg::FUNC_INSERT :
                                   (roll < 35) ? sqpq_pkg::FUNC_PEEK :
                                   (roll < 70) ? sqpq_pkg::FUNC_ADVANCE :
                                   (roll < 85) ? sqpq_pkg::FUNC_REMOVE :
                                                 sqpq_pkg::FUNC_REWIND;
                    2: func_code = (roll < 55) ? sqpq_pkg::FUNC_REMOVE :
                                   (roll < 70) ? sqpq_pkg::FUNC_REWIND :
                                   (roll < 85) ? sqpq_pkg::FUNC_ADVANCE :
                                                 sqpq_pkg::FUNC_INSERT;
                    default: func_code = $urandom_range(0, 7);
                endcase
                item = make_req(func_code, pick_key(), pick_key(), $urandom);
                pace_sender(phase % 4 == 2);
                drive_request(item, 1'b0, '0);
            end
            req_ch.valid <= 1'b0;
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            report_mismatch("responses still outstanding", 32'(pending_rsp.size()), 32'd0);
        end
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
